FILE: src/pfs_pkg.sv
// Shared types, constants and codes for the palette fade scheduler.
`default_nettype none
package pfs_pkg;
  localparam int unsigned EffectSlotsDef    = 8;
  localparam int unsigned PaletteEntriesDef = 256;
  localparam int unsigned ColorW = 8;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned FrameW = 16;
  localparam int unsigned SlotW  = 3;
  localparam int unsigned StepsW = 10;
  // product s*(diff): s up to 1023 (11 bits unsigned), diff 9 bits signed
  localparam int unsigned ProdW  = 20;

  typedef enum logic [1:0] {
    ACT_STORE = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef struct packed {
    logic             valid;
    logic             fade_out;
    logic [StepsW-1:0] steps;
    logic [FrameW-1:0] start;
    logic [ColorW-1:0] r;
    logic [ColorW-1:0] g;
    logic [ColorW-1:0] b;
  } fx_slot_t;

  // controller -> datapath
  typedef struct packed {
    logic       clear;      // zero one palette entry
    logic       capture;    // latch input item
    logic       pal_write;  // write base palette
    logic       slot_write; // write effect slot
    logic       scan_init;  // start slot scan
    logic       scan_step;  // examine one slot
    logic       chan_load;  // load divider for current channel
    logic       div_step;   // one divider iteration
    logic       chan_store; // store finished channel
    logic [1:0] chan;       // channel select
    logic       finish;     // present result
  } pfs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       clear_done;
    logic [1:0] action;
    logic       scan_done;
    logic       hit;
    logic       div_done;
  } pfs_sts_t;
endpackage
`default_nettype wire

FILE: src/palette_fade_scheduler.sv
// Top level of the palette fade scheduler.
// Channel   | handshake           | payload
// command   | start / busy        | action_i .. effect_start_i
// result    | done_o (1 cycle)    | out_red_o .. passthrough_o
// A transfer in is taken when start is high and busy is low.
// Store and load pass from the capture through dispatch to the finishing
// state, as does an unused action. A query reads the palette, then scans the
// slots from the highest down until a match; a hit adds the three per-channel
// divisions on the one shared serial divider (20 quotient bits each).
// Reset clears slots, fade flag and control, then a clearing pass zeroes the
// palette RAM one entry per cycle (busy held high).
// The receiver cannot stall: done_o marks the single cycle that carries each
// result transfer.
`default_nettype none
module palette_fade_scheduler #(
  parameter int unsigned EffectSlots    = pfs_pkg::EffectSlotsDef,
  parameter int unsigned PaletteEntries = pfs_pkg::PaletteEntriesDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 action_i,
  input  wire logic [pfs_pkg::IdxW-1:0]   entry_index_i,
  input  wire logic [pfs_pkg::ColorW-1:0] red_i,
  input  wire logic [pfs_pkg::ColorW-1:0] green_i,
  input  wire logic [pfs_pkg::ColorW-1:0] blue_i,
  input  wire logic [pfs_pkg::FrameW-1:0] frame_i,
  input  wire logic [pfs_pkg::SlotW-1:0]  slot_i,
  input  wire logic                       effect_valid_i,
  input  wire logic                       fade_out_i,
  input  wire logic [pfs_pkg::StepsW-1:0] effect_steps_i,
  input  wire logic [pfs_pkg::FrameW-1:0] effect_start_i,
  output logic                            done_o,
  output logic [pfs_pkg::ColorW-1:0]      out_red_o,
  output logic [pfs_pkg::ColorW-1:0]      out_green_o,
  output logic [pfs_pkg::ColorW-1:0]      out_blue_o,
  output logic [pfs_pkg::IdxW-1:0]        out_index_o,
  output logic                            fading_o,
  output logic                            passthrough_o
);
  import pfs_pkg::*;

  pfs_cmd_t cmd;
  pfs_sts_t sts;

  pfs_ctrl u_ctrl (
    .clk_i (clk_i), .rst_ni(rst_ni), .start_i(start),
    .sts_i (sts), .busy_o(busy), .cmd_o(cmd)
  );

  pfs_datapath #(.EffectSlots(EffectSlots), .PaletteEntries(PaletteEntries)) u_dp (
    .clk_i, .rst_ni, .action_i, .entry_index_i, .red_i, .green_i, .blue_i,
    .frame_i, .slot_i, .effect_valid_i, .fade_out_i, .effect_steps_i,
    .effect_start_i, .cmd_i(cmd), .sts_o(sts), .done_o, .out_red_o,
    .out_green_o, .out_blue_o, .out_index_o, .fading_o, .passthrough_o
  );

  ap_no_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");
  ap_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("transfer not taken");
  ap_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("result without item");
endmodule
`default_nettype wire

FILE: src/pfs_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module pfs_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

FILE: src/pfs_datapath.sv
// Datapath: palette, effect slots, slot scan and shared serial divider.
`default_nettype none
module pfs_datapath #(
  parameter int unsigned EffectSlots    = pfs_pkg::EffectSlotsDef,
  parameter int unsigned PaletteEntries = pfs_pkg::PaletteEntriesDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [1:0]                 action_i,
  input  wire logic [pfs_pkg::IdxW-1:0]   entry_index_i,
  input  wire logic [pfs_pkg::ColorW-1:0] red_i,
  input  wire logic [pfs_pkg::ColorW-1:0] green_i,
  input  wire logic [pfs_pkg::ColorW-1:0] blue_i,
  input  wire logic [pfs_pkg::FrameW-1:0] frame_i,
  input  wire logic [pfs_pkg::SlotW-1:0]  slot_i,
  input  wire logic                       effect_valid_i,
  input  wire logic                       fade_out_i,
  input  wire logic [pfs_pkg::StepsW-1:0] effect_steps_i,
  input  wire logic [pfs_pkg::FrameW-1:0] effect_start_i,
  input  wire pfs_pkg::pfs_cmd_t          cmd_i,
  output pfs_pkg::pfs_sts_t               sts_o,
  output logic                            done_o,
  output logic [pfs_pkg::ColorW-1:0]      out_red_o,
  output logic [pfs_pkg::ColorW-1:0]      out_green_o,
  output logic [pfs_pkg::ColorW-1:0]      out_blue_o,
  output logic [pfs_pkg::IdxW-1:0]        out_index_o,
  output logic                            fading_o,
  output logic                            passthrough_o
);
  import pfs_pkg::*;

  localparam int unsigned PalAw  = $clog2(PaletteEntries);
  localparam int unsigned SlotIw = (EffectSlots > 1) ? $clog2(EffectSlots) : 1;
  localparam int unsigned CntW   = $clog2(EffectSlots + 1);
  localparam int unsigned QW     = ProdW;   // quotient magnitude bits
  localparam int unsigned RemW   = StepsW + 1;
  localparam int unsigned DivCntW = $clog2(QW + 1);

  // captured item
  logic [1:0]        act_q;
  logic [IdxW-1:0]   idx_q;
  logic [ColorW-1:0] col_q [3];
  logic [FrameW-1:0] frame_q;
  logic [SlotW-1:0]  slot_q;
  logic              ev_q, fo_q;
  logic [StepsW-1:0] steps_q;
  logic [FrameW-1:0] start_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q   <= action_i;
      idx_q   <= entry_index_i;
      col_q[0] <= red_i;
      col_q[1] <= green_i;
      col_q[2] <= blue_i;
      frame_q <= frame_i;
      slot_q  <= slot_i;
      ev_q    <= effect_valid_i;
      fo_q    <= fade_out_i;
      steps_q <= effect_steps_i;
      start_q <= effect_start_i;
    end
  end

  wire idx_in = ({24'd0, idx_q} < 32'(PaletteEntries));
  wire slot_in = ({29'd0, slot_q} < 32'(EffectSlots));

  // palette clearing pass after reset, one entry per cycle
  logic [PalAw-1:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + PalAw'(1);
    end
  end

  // base palette memory, registered read at the captured index
  logic [3*ColorW-1:0] pal_rdata;
  pfs_ram #(.Width(3*ColorW), .Depth(PaletteEntries)) u_pal (
    .clk_i  (clk_i),
    .we_i   (cmd_i.clear || (cmd_i.pal_write && idx_in)),
    .addr_i (cmd_i.clear ? clr_q : idx_q[PalAw-1:0]),
    .wdata_i(cmd_i.clear ? {(3*ColorW){1'b0}} : {col_q[0], col_q[1], col_q[2]}),
    .rdata_o(pal_rdata)
  );

  // effect slot table; few entries, scanned one per cycle
  fx_slot_t slots_q [EffectSlots];
  logic     active_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < EffectSlots; i++) slots_q[i] <= '0;
    end else if (cmd_i.slot_write && slot_in) begin
      slots_q[slot_q[SlotIw-1:0]] <= '{valid: ev_q, fade_out: fo_q, steps: steps_q,
                                        start: start_q, r: col_q[0], g: col_q[1],
                                        b: col_q[2]};
    end
  end

  // scan from highest slot downward
  logic [CntW-1:0] scan_q;
  logic            hit_q;
  fx_slot_t        hit_fx_q;
  fx_slot_t        cur_fx;
  logic [FrameW:0] end_fr;
  logic            match;
  always_comb begin
    cur_fx = slots_q[SlotIw'(scan_q - CntW'(1))];
    end_fr = {1'b0, cur_fx.start} + {7'd0, cur_fx.steps} - (FrameW+1)'(1);
    match  = cur_fx.valid && (cur_fx.steps != '0) && (frame_q >= cur_fx.start)
             && ({1'b0, frame_q} <= end_fr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
      hit_q  <= 1'b0;
    end else if (cmd_i.scan_init) begin
      scan_q <= CntW'(EffectSlots);
      hit_q  <= 1'b0;
    end else if (cmd_i.scan_step && !hit_q && scan_q != '0) begin
      scan_q <= scan_q - CntW'(1);
      if (match) begin
        hit_q    <= 1'b1;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step && !hit_q && scan_q != '0 && match) hit_fx_q <= cur_fx;
  end

  logic [ColorW-1:0] base_q [3];
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      base_q[0] <= idx_in ? pal_rdata[3*ColorW-1:2*ColorW] : '0;
      base_q[1] <= idx_in ? pal_rdata[2*ColorW-1:ColorW]   : '0;
      base_q[2] <= idx_in ? pal_rdata[ColorW-1:0]          : '0;
    end
  end

  // channel operands: r = a - s*(a-c)/n, a = base (fade out) or color (fade in)
  logic [ColorW-1:0] fx_col, a_sel, c_sel;
  logic signed [ColorW:0] diff;
  logic [StepsW:0] step_n;
  logic [ProdW-1:0] mag_prod;
  logic [ColorW:0] diff_mag;
  always_comb begin
    case (cmd_i.chan)
      2'd0:    fx_col = hit_fx_q.r;
      2'd1:    fx_col = hit_fx_q.g;
      default: fx_col = hit_fx_q.b;
    endcase
    a_sel    = hit_fx_q.fade_out ? base_q[cmd_i.chan] : fx_col;
    c_sel    = hit_fx_q.fade_out ? fx_col : base_q[cmd_i.chan];
    diff     = $signed({1'b0, a_sel}) - $signed({1'b0, c_sel});
    diff_mag = diff[ColorW] ? (ColorW+1)'(0) - $unsigned(diff) : $unsigned(diff);
    step_n   = (StepsW+1)'(frame_q - hit_fx_q.start) + (StepsW+1)'(1);
    mag_prod = ProdW'(step_n) * ProdW'(diff_mag);
  end

  // restoring divider on magnitudes, one quotient bit per cycle
  logic [QW-1:0]      dq_q;
  logic [RemW-1:0]    rem_q;
  logic [DivCntW-1:0] dcnt_q;
  logic               neg_q;
  logic [ColorW-1:0]  a_q;
  logic [RemW-1:0]    trial;
  always_comb trial = {rem_q[RemW-2:0], dq_q[QW-1]} - {1'b0, hit_fx_q.steps};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.chan_load) begin
      dcnt_q <= DivCntW'(QW);
    end else if (cmd_i.div_step && dcnt_q != '0) begin
      dcnt_q <= dcnt_q - DivCntW'(1);
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.chan_load) begin
      dq_q  <= mag_prod;
      rem_q <= '0;
      neg_q <= diff[ColorW];
      a_q   <= a_sel;
    end else if (cmd_i.div_step && dcnt_q != '0) begin
      if (!trial[RemW-1]) begin
        rem_q <= trial;
        dq_q  <= {dq_q[QW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[RemW-2:0], dq_q[QW-1]};
        dq_q  <= {dq_q[QW-2:0], 1'b0};
      end
    end
  end

  logic [ColorW-1:0] res_q [3];
  always_ff @(posedge clk_i) begin
    if (cmd_i.chan_store) begin
      // a - q, q signed with sign neg_q; low 8 bits only
      res_q[cmd_i.chan] <= neg_q ? a_q + dq_q[ColorW-1:0] : a_q - dq_q[ColorW-1:0];
    end
  end

  // result register and fade flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_o   <= 1'b0;
    end else begin
      done_o <= cmd_i.finish;
      if (cmd_i.finish) begin
        if (act_q == ACT_QUERY) active_q <= hit_q;
        else if (act_q == ACT_LOAD && slot_in && ev_q && start_q <= FrameW'(1))
          active_q <= 1'b1;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      unique case (act_q)
        ACT_STORE: begin
          out_red_o <= col_q[0]; out_green_o <= col_q[1]; out_blue_o <= col_q[2];
          out_index_o <= idx_q; fading_o <= 1'b0;
          passthrough_o <= idx_in && !active_q;
        end
        ACT_QUERY: begin
          out_red_o   <= hit_q ? res_q[0] : base_q[0];
          out_green_o <= hit_q ? res_q[1] : base_q[1];
          out_blue_o  <= hit_q ? res_q[2] : base_q[2];
          out_index_o <= idx_q; fading_o <= hit_q; passthrough_o <= 1'b0;
        end
        default: begin
          out_red_o <= '0; out_green_o <= '0; out_blue_o <= '0;
          out_index_o <= '0; fading_o <= 1'b0; passthrough_o <= 1'b0;
        end
      endcase
    end
  end

  assign sts_o = '{clear_done: (clr_q == PalAw'(PaletteEntries - 1)), action: act_q,
                   scan_done: (hit_q || scan_q == '0), hit: hit_q,
                   div_done: (dcnt_q == '0)};

  ap_div_idle_on_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.chan_store |-> dcnt_q == '0) else $error("channel stored before divide done");
  ap_scan_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.scan_step) && !$past(cmd_i.scan_init) && !cmd_i.scan_init
    |-> scan_q <= $past(scan_q)) else $error("slot scan moved upward");
  ap_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
endmodule
`default_nettype wire

FILE: src/pfs_ctrl.sv
// Controller state machine: palette clearing pass after reset, then sequencing store, load and query items.
`default_nettype none
module pfs_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire pfs_pkg::pfs_sts_t sts_i,
  output logic                   busy_o,
  output pfs_pkg::pfs_cmd_t      cmd_o
);
  import pfs_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b0_0000_0001,
    ST_DISP  = 9'b0_0000_0010,
    ST_RDPAL = 9'b0_0000_0100,
    ST_SCAN  = 9'b0_0000_1000,
    ST_LOAD  = 9'b0_0001_0000,
    ST_DIV   = 9'b0_0010_0000,
    ST_STORE = 9'b0_0100_0000,
    ST_DONE  = 9'b0_1000_0000,
    ST_CLEAR = 9'b1_0000_0000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] chan_q, chan_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      chan_q  <= '0;
    end else begin
      state_q <= state_d;
      chan_q  <= chan_d;
    end
  end

  always_comb begin
    state_d = state_q;
    chan_d  = chan_q;
    cmd_o   = '0;
    cmd_o.chan = chan_q;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        unique case (sts_i.action)
          ACT_STORE: begin cmd_o.pal_write = 1'b1; state_d = ST_DONE; end
          ACT_LOAD:  begin cmd_o.slot_write = 1'b1; state_d = ST_DONE; end
          ACT_QUERY: state_d = ST_RDPAL;
          default:   state_d = ST_DONE;
        endcase
      end
      ST_RDPAL: begin cmd_o.scan_init = 1'b1; state_d = ST_SCAN; end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          chan_d  = '0;
          state_d = sts_i.hit ? ST_LOAD : ST_DONE;
        end
      end
      ST_LOAD: begin cmd_o.chan_load = 1'b1; state_d = ST_DIV; end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = ST_STORE;
      end
      ST_STORE: begin
        cmd_o.chan_store = 1'b1;
        chan_d = chan_q + 2'd1;
        state_d = (chan_q == 2'd2) ? ST_DONE : ST_LOAD;
      end
      ST_DONE: begin cmd_o.finish = 1'b1; state_d = ST_IDLE; end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  ap_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  ap_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> !busy_o) else $error("busy after finish");
  ap_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.chan_load |-> chan_q != 2'd3) else $error("bad channel");
endmodule
`default_nettype wire
